FILE: rtl/jlts_pkg.sv
// ----------------------------------------------------------------------------
// jlts_pkg
// shared widths, scale codes and types for the joint-limit task scale block
// ----------------------------------------------------------------------------
package jlts_pkg;

  localparam int unsigned VALUE_W = 32;  // Q16.16 joint quantities
  localparam int unsigned QUOT_W  = 16;  // Q0.16 quotient bits
  localparam int unsigned SCALE_W = 17;  // quotient plus the 1.0 / infinite codes
  localparam int unsigned INDEX_W = 4;

  localparam logic [SCALE_W-1:0] SCALE_ZERO = '0;
  localparam logic [SCALE_W-1:0] SCALE_ONE  = SCALE_W'(1) << QUOT_W;
  localparam logic [SCALE_W-1:0] SCALE_INF  = SCALE_ONE + SCALE_W'(1);

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [SCALE_W-1:0]        scale_t;
  typedef logic [INDEX_W-1:0]        index_t;

endpackage

FILE: rtl/jlts_joint_if.sv
// ----------------------------------------------------------------------------
// jlts_joint_if
// request channel carrying one joint's step, output, bounds and flags
// ----------------------------------------------------------------------------
interface jlts_joint_if
  import jlts_pkg::*;
();

  logic   valid;
  logic   ready;
  value_t solved_step;
  value_t joint_output;
  value_t bound_low;
  value_t bound_high;
  logic   joint_free;
  logic   joint_last;

  modport source (
    output valid, solved_step, joint_output, bound_low, bound_high, joint_free, joint_last,
    input  ready
  );

  modport sink (
    input  valid, solved_step, joint_output, bound_low, bound_high, joint_free, joint_last,
    output ready
  );

endinterface

FILE: rtl/jlts_result_if.sv
// ----------------------------------------------------------------------------
// jlts_result_if
// result channel carrying the minimum scale, its joint and the overflow flag
// ----------------------------------------------------------------------------
interface jlts_result_if
  import jlts_pkg::*;
();

  logic   valid;
  logic   ready;
  scale_t task_scale;
  index_t critical_joint;
  logic   joint_overflow;

  modport source (
    output valid, task_scale, critical_joint, joint_overflow,
    input  ready
  );

  modport sink (
    input  valid, task_scale, critical_joint, joint_overflow,
    output ready
  );

endinterface

FILE: rtl/joint_limit_task_scale_min.sv
// ----------------------------------------------------------------------------
// joint_limit_task_scale_min
// minimum feasible task scale over a set of joints, with its joint index
// ----------------------------------------------------------------------------
// One joint is taken per request and the block works on it alone. A joint
// that needs a quotient passes through these steps from acceptance to the
// next ready: take the request and form output minus step, form the two
// margins, classify, run the radix-2 restoring divider that produces the
// Q0.16 quotient a bit per cycle, and fold the scale into the running
// minimum. Locked joints and joints that need no quotient skip the divider;
// joints beyond MAX_JOINTS go from acceptance straight to the fold. The
// result of a set is held in an output register, so the next set's joints
// are taken while it waits; only the final joint of a set stalls in its
// fold step while an earlier result is still unread.
// ----------------------------------------------------------------------------
module joint_limit_task_scale_min
  import jlts_pkg::*;
#(
  parameter int unsigned MAX_JOINTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  jlts_joint_if.sink         joints,
  jlts_result_if.source      result
);

  localparam int unsigned CNT_W = $clog2(MAX_JOINTS + 1);
  localparam int unsigned EXT_W = CNT_W + INDEX_W;
  localparam int unsigned DIV_W = $clog2(QUOT_W);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MARGIN = 5'b00010,
    S_CLASS  = 5'b00100,
    S_DIV    = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  state_t state;

  // joint under work
  value_t                  a_r;
  value_t                  lo_r;
  value_t                  hi_r;
  logic signed [VALUE_W:0]   b_r;
  logic signed [VALUE_W+1:0] low_r;
  logic signed [VALUE_W+1:0] high_r;
  logic                    free_r;
  logic                    last_r;
  logic                    ignore_r;
  scale_t                  scale_r;

  // divider
  logic [VALUE_W-1:0]      rem;
  logic [VALUE_W-1:0]      den;
  logic [QUOT_W-1:0]       quot;
  logic [DIV_W-1:0]        div_cnt;

  // set state
  scale_t                  best_scale;
  index_t                  best_index;
  logic [CNT_W-1:0]        joint_counter;
  logic                    overflow_seen;

  // output register
  logic                    out_valid;
  scale_t                  out_scale;
  index_t                  out_index;
  logic                    out_overflow;

  logic signed [VALUE_W+1:0] a_ext;
  logic signed [VALUE_W+1:0] neg_low;
  logic signed [VALUE_W+1:0] neg_a;
  logic [VALUE_W+1:0]        trial;
  logic                      qbit;
  logic [VALUE_W-1:0]        rem_next;
  logic [EXT_W-1:0]          cnt_ext;
  logic                      better;
  scale_t                    best_scale_next;
  index_t                    best_index_next;
  logic                      overflow_next;
  logic                      fin_go;
  logic                      out_load;

  assign a_ext   = (VALUE_W+2)'(a_r);
  assign neg_low = -low_r;
  assign neg_a   = -a_ext;

  // restoring step: shift remainder left, try subtracting the divisor
  assign trial    = {1'b0, rem, 1'b0} - {2'b00, den};
  assign qbit     = ~trial[VALUE_W+1];
  assign rem_next = qbit ? trial[VALUE_W-1:0] : {rem[VALUE_W-2:0], 1'b0};

  assign cnt_ext = EXT_W'(joint_counter);
  assign better  = (joint_counter == '0) || (scale_r < best_scale);

  always_comb begin
    best_scale_next = best_scale;
    best_index_next = best_index;
    overflow_next   = overflow_seen;
    if (ignore_r) begin
      overflow_next = 1'b1;
    end else if (better) begin
      best_scale_next = scale_r;
      best_index_next = cnt_ext[INDEX_W-1:0];
    end
  end

  assign fin_go   = !last_r || !out_valid || result.ready;
  assign out_load = (state == S_FIN) && fin_go && last_r;

  assign joints.ready          = (state == S_IDLE);
  assign result.valid          = out_valid;
  assign result.task_scale     = out_scale;
  assign result.critical_joint = out_index;
  assign result.joint_overflow = out_overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      best_scale    <= SCALE_ZERO;
      best_index    <= '0;
      joint_counter <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (joints.valid) begin
            a_r      <= joints.solved_step;
            lo_r     <= joints.bound_low;
            hi_r     <= joints.bound_high;
            b_r      <= (VALUE_W+1)'(joints.joint_output) - (VALUE_W+1)'(joints.solved_step);
            free_r   <= joints.joint_free;
            last_r   <= joints.joint_last;
            ignore_r <= (joint_counter >= CNT_W'(MAX_JOINTS));
            state    <= (joint_counter >= CNT_W'(MAX_JOINTS)) ? S_FIN : S_MARGIN;
          end
        end
        S_MARGIN: begin
          low_r  <= (VALUE_W+2)'(lo_r) - (VALUE_W+2)'(b_r);
          high_r <= (VALUE_W+2)'(hi_r) - (VALUE_W+2)'(b_r);
          state  <= S_CLASS;
        end
        S_CLASS: begin
          div_cnt <= '0;
          quot    <= '0;
          state   <= S_FIN;
          if (!free_r) begin
            scale_r <= SCALE_INF;
          end else if (a_r < 0 && low_r < 0) begin
            if (a_ext < low_r) begin
              rem   <= neg_low[VALUE_W-1:0];
              den   <= neg_a[VALUE_W-1:0];
              state <= S_DIV;
            end else begin
              scale_r <= SCALE_ONE;
            end
          end else if (a_r > 0 && high_r > 0) begin
            if (high_r < a_ext) begin
              rem   <= high_r[VALUE_W-1:0];
              den   <= a_r[VALUE_W-1:0];
              state <= S_DIV;
            end else begin
              scale_r <= SCALE_ONE;
            end
          end else begin
            scale_r <= SCALE_ZERO;
          end
        end
        S_DIV: begin
          rem     <= rem_next;
          quot    <= {quot[QUOT_W-2:0], qbit};
          div_cnt <= div_cnt + DIV_W'(1);
          if (div_cnt == DIV_W'(QUOT_W - 1)) begin
            scale_r <= SCALE_W'({quot[QUOT_W-2:0], qbit});
            state   <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            state <= S_IDLE;
            if (last_r) begin
              out_scale     <= best_scale_next;
              out_index     <= best_index_next;
              out_overflow  <= overflow_next;
              best_scale    <= SCALE_ZERO;
              best_index    <= '0;
              joint_counter <= '0;
              overflow_seen <= 1'b0;
            end else begin
              best_scale    <= best_scale_next;
              best_index    <= best_index_next;
              overflow_seen <= overflow_next;
              if (!ignore_r) begin
                joint_counter <= joint_counter + CNT_W'(1);
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: verif/joint_limit_task_scale_min_tb.sv
// ----------------------------------------------------------------------------
// joint_limit_task_scale_min_tb
// self-checking bench for the minimum task scale over sets of joints
// ----------------------------------------------------------------------------
// Joint requests go in one at a time through the request channel and are
// predicted as they are accepted. The predictor keeps its own running
// minimum, joint count and overflow flag. Each result is compared field by
// field with the oldest prediction. Directed sets cover locked joints, zero
// steps, overshoot in both directions, infeasible margins, extreme field
// values, ties and sets longer than the joint cap. Random sets follow, under
// several idle and stall patterns.
// ----------------------------------------------------------------------------
module joint_limit_task_scale_min_tb;
  import jlts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned JOINT_CAP     = 16;
  localparam int          RANDOM_ITEMS  = 1725;
  localparam int          IDLE_LIMIT    = 4000;
  localparam int          REPORT_LIMIT  = 10;

  typedef struct {
    value_t solved_step;
    value_t joint_output;
    value_t bound_low;
    value_t bound_high;
    logic   joint_free;
    logic   joint_last;
  } joint_req_t;

  typedef struct {
    scale_t task_scale;
    index_t critical_joint;
    logic   joint_overflow;
  } set_minimum_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  jlts_joint_if  joints ();
  jlts_result_if result ();

  joint_limit_task_scale_min #(
    .MAX_JOINTS(JOINT_CAP)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .joints (joints),
    .result (result)
  );

  always #2 clk = ~clk;

  // predictor state
  scale_t       min_scale;
  index_t       min_index;
  int unsigned  joints_in_set;
  logic         set_overflow;
  set_minimum_t pending_minima[$];

  int          mismatches;
  int          idle_cycles;
  int          send_idle_pct;
  int          stall_pct;
  int          items_sent;
  joint_req_t  prev_joint;

  initial begin
    joints.valid        = 1'b0;
    joints.solved_step  = '0;
    joints.joint_output = '0;
    joints.bound_low    = '0;
    joints.bound_high   = '0;
    joints.joint_free   = 1'b0;
    joints.joint_last   = 1'b0;
    result.ready        = 1'b0;
  end

  function automatic scale_t q016_ratio(longint unsigned num, longint unsigned den);
    return scale_t'((num << QUOT_W) / den);
  endfunction

  function automatic scale_t margin_scale(joint_req_t j);
    longint step;
    longint base;
    longint low_m;
    longint high_m;
    step   = longint'(j.solved_step);
    base   = longint'(j.joint_output) - step;
    low_m  = longint'(j.bound_low) - base;
    high_m = longint'(j.bound_high) - base;
    if (!j.joint_free) return SCALE_INF;
    if (step < 0 && low_m < 0) begin
      if (step < low_m) return q016_ratio(-low_m, -step);
      return SCALE_ONE;
    end
    if (step > 0 && high_m > 0) begin
      if (high_m < step) return q016_ratio(high_m, step);
      return SCALE_ONE;
    end
    return SCALE_ZERO;
  endfunction

  function automatic void clear_set();
    min_scale     = SCALE_ZERO;
    min_index     = '0;
    joints_in_set = 0;
    set_overflow  = 1'b0;
  endfunction

  function automatic void fold_joint(joint_req_t j);
    scale_t s;
    set_minimum_t m;
    if (joints_in_set >= JOINT_CAP) begin
      set_overflow = 1'b1;
    end else begin
      s = margin_scale(j);
      // strict compare keeps the first joint on ties
      if (joints_in_set == 0 || s < min_scale) begin
        min_scale = s;
        min_index = index_t'(joints_in_set);
      end
      joints_in_set++;
    end
    if (j.joint_last) begin
      m.task_scale     = min_scale;
      m.critical_joint = min_index;
      m.joint_overflow = set_overflow;
      pending_minima.push_back(m);
      clear_set();
    end
  endfunction

  function automatic joint_req_t make_joint(int step, int outv, int lo, int hi,
                                            logic free, logic last);
    joint_req_t j;
    j.solved_step  = value_t'(step);
    j.joint_output = value_t'(outv);
    j.bound_low    = value_t'(lo);
    j.bound_high   = value_t'(hi);
    j.joint_free   = free;
    j.joint_last   = last;
    return j;
  endfunction

  function automatic int rand_signed(int unsigned mag);
    int v;
    v = int'($urandom_range(0, mag));
    return ($urandom_range(0, 1) == 1) ? -v : v;
  endfunction

  task automatic send_joint(joint_req_t j);
    int gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? int'($urandom_range(1, 6)) : 0;
    @(negedge clk);
    if (gap > 0) begin
      joints.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    joints.solved_step  = j.solved_step;
    joints.joint_output = j.joint_output;
    joints.bound_low    = j.bound_low;
    joints.bound_high   = j.bound_high;
    joints.joint_free   = j.joint_free;
    joints.joint_last   = j.joint_last;
    joints.valid        = 1'b1;
    do @(posedge clk); while (!joints.ready);
    fold_joint(j);
    prev_joint = j;
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    joints.valid = 1'b0;
    while (pending_minima.size() != 0) @(posedge clk);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    result.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    set_minimum_t exp_m;
    if (!rst && result.valid && result.ready) begin
      if (pending_minima.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: scale %0d joint %0d overflow %0b",
                   result.task_scale, result.critical_joint, result.joint_overflow);
      end else begin
        exp_m = pending_minima.pop_front();
        if (result.task_scale !== exp_m.task_scale ||
            result.critical_joint !== exp_m.critical_joint ||
            result.joint_overflow !== exp_m.joint_overflow) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result mismatch: scale exp %0d got %0d, joint exp %0d got %0d, %s",
                     exp_m.task_scale, result.task_scale,
                     exp_m.critical_joint, result.critical_joint,
                     $sformatf("overflow exp %0b got %0b",
                               exp_m.joint_overflow, result.joint_overflow));
        end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (rst || (joints.valid && joints.ready) || (result.valid && result.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_single_joint_cases();
    // locked joint gives infinite scale
    send_joint(make_joint(32'h0001_0000, 32'h0001_0000, -32'h0001_0000, 32'h0001_0000,
                          1'b0, 1'b1));
    // zero step
    send_joint(make_joint(0, 32'h0002_0000, -32'h0001_0000, 32'h0001_0000, 1'b1, 1'b1));
    // step inside both margins
    send_joint(make_joint(32'h0000_8000, 32'h0000_8000, -32'h0002_0000, 32'h0002_0000,
                          1'b1, 1'b1));
    // positive overshoot, one third
    send_joint(make_joint(32'h0003_0000, 32'h0003_0000, -32'h0001_0000, 32'h0001_0000,
                          1'b1, 1'b1));
    // negative overshoot, one quarter
    send_joint(make_joint(-32'h0004_0000, -32'h0004_0000, -32'h0001_0000, 32'h0001_0000,
                          1'b1, 1'b1));
  endtask

  task automatic test_extreme_values();
    // step away from a margin of the wrong sign
    send_joint(make_joint(-32'h0001_0000, -32'h0001_0000, 32'h0000_8000, 32'h0002_0000,
                          1'b1, 1'b0));
    send_joint(make_joint(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                          1'b1, 1'b0));
    send_joint(make_joint(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                          1'b1, 1'b0));
    send_joint(make_joint(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                          1'b1, 1'b1));
  endtask

  task automatic test_tie_keeps_first();
    send_joint(make_joint(32'h0003_0000, 32'h0003_0000, -32'h0001_0000, 32'h0001_0000,
                          1'b1, 1'b0));
    send_joint(make_joint(32'h0003_0000, 32'h0003_0000, -32'h0001_0000, 32'h0001_0000,
                          1'b1, 1'b0));
    send_joint(make_joint(0, 0, 0, 0, 1'b0, 1'b1));
  endtask

  task automatic test_joint_overflow();
    int k;
    // minimum on the last counted joint, then one joint past the cap marked last
    for (k = 0; k < JOINT_CAP + 1; k++) begin
      if (k == JOINT_CAP - 1)
        send_joint(make_joint(32'h0004_0000, 32'h0004_0000, -32'h0001_0000,
                              32'h0001_0000, 1'b1, 1'b0));
      else
        send_joint(make_joint(32'h0000_8000, 32'h0000_8000, -32'h0002_0000,
                              32'h0002_0000, 1'b1, k == JOINT_CAP));
    end
  endtask

  function automatic joint_req_t random_joint(logic last);
    joint_req_t j;
    int mode;
    int base;
    int step;
    int mag;
    int margin;
    mode = int'($urandom_range(0, 9));
    if (mode <= 1 || mode == 9) begin
      j.solved_step  = value_t'($urandom);
      j.joint_output = value_t'($urandom);
      j.bound_low    = value_t'($urandom);
      j.bound_high   = value_t'($urandom);
      j.joint_free   = (mode == 9) ? 1'b0 : logic'($urandom_range(0, 1));
    end else if (mode == 8) begin
      j = prev_joint;
    end else begin
      // step against a margin built to overshoot, fit or point the wrong way
      base = rand_signed(1 << 24);
      mag  = int'($urandom_range(1, 1 << 22));
      case ($urandom_range(0, 2))
        0: margin = int'($urandom_range(1, mag));
        1: margin = mag + int'($urandom_range(0, 1 << 20));
        default: margin = -int'($urandom_range(0, 1 << 20));
      endcase
      step = ($urandom_range(0, 15) == 0) ? 0 : mag;
      if ($urandom_range(0, 1) == 1) begin
        j.bound_high = value_t'(base + margin);
        j.bound_low  = value_t'(base + rand_signed(1 << 22));
      end else begin
        step = -step;
        j.bound_low  = value_t'(base - margin);
        j.bound_high = value_t'(base + rand_signed(1 << 22));
      end
      j.solved_step  = value_t'(step);
      j.joint_output = value_t'(base + step);
      j.joint_free   = ($urandom_range(0, 19) != 0);
    end
    j.joint_last = last;
    return j;
  endfunction

  task automatic test_random_sets(int idle_pct, int stall, int budget);
    int stop_at;
    int set_len;
    int k;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    stop_at       = items_sent + budget;
    while (items_sent < stop_at) begin
      set_len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(JOINT_CAP + 1, JOINT_CAP + 4))
                                            : int'($urandom_range(1, JOINT_CAP));
      for (k = 0; k < set_len; k++) send_joint(random_joint(k == set_len - 1));
    end
    wait_drained();
  endtask

  initial begin
    mismatches    = 0;
    idle_cycles   = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    items_sent    = 0;
    prev_joint    = make_joint(0, 0, 0, 0, 1'b1, 1'b0);
    clear_set();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_single_joint_cases();
    test_extreme_values();
    test_tie_keeps_first();
    test_joint_overflow();
    // hold requests until every set result is back
    wait_drained();

    test_random_sets(0, 0, RANDOM_ITEMS / 4);
    test_random_sets(48, 0, RANDOM_ITEMS / 4);
    test_random_sets(0, 48, RANDOM_ITEMS / 4);
    test_random_sets(6, 6, RANDOM_ITEMS / 4);

    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_minima.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
